/* hdl/rpsd_pkg.sv */
package rpsd_pkg;

   localparam int unsigned READING_W = 64;
   localparam int unsigned SENSOR_W  = 16;
   localparam int unsigned THRESH_W  = 16;
   localparam int unsigned WEIGHT_W  = 16;
   localparam int unsigned SCORE_W   = 32;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 16'hFFFF;
   localparam logic [SCORE_W-1:0]  SCORE_MAX    = 32'hFFFF_FFFF;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_MERGE
   } state_type;

   typedef struct packed {
      logic               stuck;
      logic               seen_before;
      logic [SCORE_W-1:0] score_now;
   } rsp_type;

endpackage

/* hdl/rpsd_lane.sv */
module rpsd_lane
   import rpsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 accept,
   input  logic                 wr_en,
   input  logic                 cmp_en,
   input  logic [READING_W-1:0] reading,
   output logic                 match
);

   logic [READING_W-1:0] entry_ff;
   logic                 match_ff;

   // compare against the old entry, then overwrite it on the same edge
   always_ff @(posedge clock) begin
      if (accept) begin
         match_ff <= cmp_en && (entry_ff == reading);
         if (wr_en) begin
            entry_ff <= reading;
         end
      end
   end

   assign match = match_ff;

endmodule

/* hdl/rpsd_merge.sv */
module rpsd_merge
   import rpsd_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [HISTORY_DEPTH-1:0] match_vec,
   input  logic [THRESH_W-1:0]      threshold,
   output rsp_type                  rsp
);

   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   rsp_type             rsp_ff, rsp_in;

   logic                seen;
   logic                stuck;
   logic [WEIGHT_W-1:0] weight_inc;
   logic [SCORE_W:0]    sum;
   logic [SCORE_W-1:0]  score_add;
   logic [SCORE_W-1:0]  score_pre;

   always_comb begin
      seen       = |match_vec;
      weight_inc = (weight_ff == WEIGHT_MAX) ? weight_ff : weight_ff + 1'b1;
      sum        = {1'b0, score_ff} + (SCORE_W + 1)'(weight_inc);
      score_add  = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
      score_pre  = seen ? score_add : (score_ff >> 1);
      stuck      = score_pre > SCORE_W'(threshold);
      weight_in  = (stuck || !seen) ? '0 : weight_inc;
      score_in   = stuck ? '0 : score_pre;
      rsp_in.stuck       = stuck;
      rsp_in.seen_before = seen;
      rsp_in.score_now   = score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         score_ff  <= '0;
      end else if (fire) begin
         weight_ff <= weight_in;
         score_ff  <= score_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* hdl/repeat_pattern_stuck_detector_unit.sv */
// Repeat-pattern stuck detector.
// req channel: one 64-bit reading of up to four 16-bit sensors per item,
// sensor 0 in the low bits; unused sensor bits are dropped.
// rsp channel: one result per item: stuck flag, seen-before flag and the
// 32-bit score after the update.
// csr port: csr_wr_en with csr_wr_data writes the stuck threshold at once.
// Every history entry has its own lane that compares the new reading with
// the stored one on the accept edge; the merge stage ORs the lane hits and
// updates weight and score in ST_MERGE once the output slot is free.
// The result is registered when the merge fires and held until taken.
// The unit takes a new item only in ST_IDLE, so no item is accepted while
// the merge of the last one is still waiting.
// Reset clears fill count, write pointer, weight, score and the threshold
// (to 100); the history contents stay undefined and are masked by the fill
// count. When the receiver stalls, the result is held and one more item may
// be accepted and compared; its merge waits until the result is taken.
module repeat_pattern_stuck_detector_unit
   import rpsd_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = 16,
   parameter int unsigned NUM_SENSORS   = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [READING_W-1:0] req_sensor_values,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_stuck,
   output logic                 rsp_seen_before,
   output logic [SCORE_W-1:0]   rsp_score_now,
   input  logic                 csr_wr_en,
   input  logic [THRESH_W-1:0]  csr_wr_data
);

   localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [READING_W-1:0] READ_MASK = (NUM_SENSORS >= 4) ? {READING_W{1'b1}} :
      ((64'd1 << (SENSOR_W * NUM_SENSORS)) - 64'd1);

   state_type           state_ff, state_in;
   logic                fire;
   logic                accept;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [THRESH_W-1:0] thresh_ff;
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [CNT_W-1:0]    filled_ff;
   logic [READING_W-1:0] reading;
   logic [HISTORY_DEPTH-1:0] match_vec;
   rsp_type             rsp;

   assign reading   = req_sensor_values & READ_MASK;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      fire     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // hold until the output slot frees up
            if (!rsp_valid_ff || rsp_ready) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         filled_ff <= '0;
      end else if (accept) begin
         wr_ptr_ff <= (wr_ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (filled_ff != CNT_W'(HISTORY_DEPTH)) begin
            filled_ff <= filled_ff + 1'b1;
         end
      end
   end

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_lane
      rpsd_lane u_lane (
         .clock   (clock),
         .accept  (accept),
         .wr_en   (wr_ptr_ff == PTR_W'(i)),
         .cmp_en  (CNT_W'(i) < filled_ff),
         .reading (reading),
         .match   (match_vec[i])
      );
   end

   rpsd_merge #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .match_vec (match_vec),
      .threshold (thresh_ff),
      .rsp       (rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stuck       = rsp.stuck;
   assign rsp_seen_before = rsp.seen_before;
   assign rsp_score_now   = rsp.score_now;

`ifndef SYNTH
   a_accept_to_merge: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MERGE)
      else $error("accepted item did not enter merge");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("fill count beyond history depth");

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      filled_ff != CNT_W'(HISTORY_DEPTH) |-> CNT_W'(wr_ptr_ff) == filled_ff)
      else $error("write pointer out of step with fill count");

   a_stuck_clears_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.stuck |-> rsp.score_now == '0)
      else $error("stuck result with nonzero score");
`endif

endmodule

/* tb/repeat_pattern_stuck_detector_unit_test.sv */
module repeat_pattern_stuck_detector_unit_test;
   import rpsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HIST_DEPTH     = 16;
   localparam int unsigned SENSORS        = 4;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 6;

   localparam logic [READING_W-1:0] SENSOR_MASK =
      (SENSORS >= 4) ? {READING_W{1'b1}} : ((64'd1 << (SENSOR_W * SENSORS)) - 64'd1);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [READING_W-1:0] req_sensor_values = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_stuck;
   logic                 rsp_seen_before;
   logic [SCORE_W-1:0]   rsp_score_now;
   logic                 csr_wr_en = 1'b0;
   logic [THRESH_W-1:0]  csr_wr_data = '0;

   repeat_pattern_stuck_detector_unit #(
      .HISTORY_DEPTH (HIST_DEPTH),
      .NUM_SENSORS   (SENSORS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensor_values (req_sensor_values),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_stuck         (rsp_stuck),
      .rsp_seen_before   (rsp_seen_before),
      .rsp_score_now     (rsp_score_now),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Detector state as predicted from accepted readings
   logic [READING_W-1:0] hist_entries [HIST_DEPTH];
   int unsigned          hist_filled = 0;
   int unsigned          hist_wr_ptr = 0;
   logic [WEIGHT_W-1:0]  repeat_wt = '0;
   logic [SCORE_W-1:0]   model_score = '0;
   logic [THRESH_W-1:0]  stuck_limit = THRESH_RESET;

   rsp_type              expected_verdicts [$];
   logic [READING_W-1:0] pending_readings [$];
   logic [READING_W-1:0] pattern_pool [$];

   int unsigned readings_queued = 0;
   int unsigned readings_taken = 0;
   int unsigned verdicts_seen = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned req_idle_left = 0;
   int unsigned req_steady_left = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_steady_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void track_reading(input logic [READING_W-1:0] raw);
      logic [READING_W-1:0] reading;
      rsp_type              verdict;
      reading = raw & SENSOR_MASK;
      verdict = '0;
      // compare before the reading overwrites its slot
      for (int i = 0; i < HIST_DEPTH; i++) begin
         if (i < hist_filled && hist_entries[i] == reading)
            verdict.seen_before = 1'b1;
      end
      hist_entries[hist_wr_ptr] = reading;
      if (hist_filled < HIST_DEPTH)
         hist_filled++;
      hist_wr_ptr = (hist_wr_ptr + 1) % HIST_DEPTH;
      if (verdict.seen_before) begin
         if (repeat_wt != WEIGHT_MAX)
            repeat_wt++;
         if (model_score > SCORE_MAX - SCORE_W'(repeat_wt))
            model_score = SCORE_MAX;
         else
            model_score = model_score + SCORE_W'(repeat_wt);
      end else begin
         repeat_wt = '0;
         model_score = model_score >> 1;
      end
      if (model_score > SCORE_W'(stuck_limit)) begin
         repeat_wt = '0;
         model_score = '0;
         verdict.stuck = 1'b1;
      end
      verdict.score_now = model_score;
      expected_verdicts.insert(expected_verdicts.size(), verdict);
   endfunction

   function automatic int unsigned next_gap(inout int unsigned steady_left);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      if (roll < 2) begin
         steady_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50)
         return 0;
      if (roll < 80)
         return $urandom_range(1, 2);
      if (roll < 96)
         return $urandom_range(3, 8);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [READING_W-1:0] next_reading(input int unsigned repeat_pct);
      logic [READING_W-1:0] pick;
      pick = pattern_pool[$urandom_range(0, pattern_pool.size() - 1)];
      if ($urandom_range(0, 99) < repeat_pct)
         return pick;
      // near miss: one bit away from a stored pattern
      if ($urandom_range(0, 3) == 0) begin
         pick[$urandom_range(0, READING_W - 1)] ^= 1'b1;
         return pick;
      end
      return {$urandom(), $urandom()};
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            track_reading(req_sensor_values);
            readings_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
               req_valid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
               req_valid <= 1'b1;
               req_sensor_values <= pending_readings.pop_front();
               req_idle_left = next_gap(req_steady_left);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected item: stuck %0b seen_before %0b score_now %0d",
                        $time, rsp_stuck, rsp_seen_before, rsp_score_now);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_stuck !== want.stuck) begin
                  $display("%0t: stuck mismatch: expected %0b, got %0b",
                           $time, want.stuck, rsp_stuck);
                  error_count++;
               end
               if (rsp_seen_before !== want.seen_before) begin
                  $display("%0t: seen_before mismatch: expected %0b, got %0b",
                           $time, want.seen_before, rsp_seen_before);
                  error_count++;
               end
               if (rsp_score_now !== want.score_now) begin
                  $display("%0t: score_now mismatch: expected %0d, got %0d",
                           $time, want.score_now, rsp_score_now);
                  error_count++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold_left = next_gap(rsp_steady_left);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (readings_taken != readings_queued || verdicts_seen < readings_taken)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      stuck_limit = value;
   endtask

   task automatic queue_reading(input logic [READING_W-1:0] reading);
      pending_readings.insert(pending_readings.size(), reading);
      readings_queued++;
   endtask

   task automatic run_phase(input logic [THRESH_W-1:0] threshold, input int unsigned count,
                            input int unsigned pool_size, input int unsigned repeat_pct);
      wait_drained();
      set_threshold(threshold);
      @(negedge clock);
      pattern_pool.delete();
      repeat (pool_size) pattern_pool.insert(pattern_pool.size(), {$urandom(), $urandom()});
      repeat (count) queue_reading(next_reading(repeat_pct));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset threshold; first reading hits an empty history
      queue_reading(64'h0000_0000_0000_0000);
      queue_reading(64'hFFFF_FFFF_FFFF_FFFF);
      queue_reading(64'h0000_0000_0000_0000);
      queue_reading(64'hFFFF_FFFF_FFFF_FFFF);
      queue_reading(64'hAAAA_AAAA_AAAA_AAAA);
      queue_reading(64'h5555_5555_5555_5555);
      queue_reading(64'h0000_0000_0000_0001);
      queue_reading(64'h8000_0000_0000_0000);
      queue_reading(64'hFFFF_0000_0000_FFFF);
      // a run of repeats crosses the threshold on the fifteenth copy
      repeat (16) queue_reading(64'h1234_5678_9ABC_DEF0);

      run_phase(16'd0, 40, 4, 70);
      // every reading is taken from the pool: the score climbs until it passes the top threshold
      run_phase(16'hFFFF, 380, 3, 100);
      run_phase(16'($urandom_range(1, 400)), 60, $urandom_range(1, 20), 80);
      run_phase(16'd1, 45, 16, 75);
      // more patterns than history slots, so old entries get evicted
      run_phase(THRESH_RESET, 50, 17, 90);

      wait_drained();
      if (expected_verdicts.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, expected_verdicts.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/rpsd_pkg.sv
hdl/rpsd_lane.sv
hdl/rpsd_merge.sv
hdl/repeat_pattern_stuck_detector_unit.sv
tb/repeat_pattern_stuck_detector_unit_test.sv
